>>> rtl/core/rmq_pkg.sv
// types and constants shared by the rotation matrix to quaternion pipeline
// no dependencies
`default_nettype none
package rmq_pkg;

  localparam int unsigned QW          = 16;     // field width, Q1.14
  localparam int unsigned NW          = 17;     // sum or difference of two elements
  localparam int unsigned SQRT_STAGES = 16;     // one root bit per stage
  localparam int unsigned DIV_STAGES  = 24;     // one quotient bit per stage
  localparam int unsigned QUO_W       = DIV_STAGES;
  localparam logic [QW-1:0] Q_ONE     = 16'd16384;

  // which component gets r/2
  typedef enum logic [1:0] {
    SEL_W = 2'd0,
    SEL_X = 2'd1,
    SEL_Y = 2'd2,
    SEL_Z = 2'd3
  } sel_e;

  typedef struct packed {
    sel_e                 sel;
    logic signed [NW-1:0] n0;
    logic signed [NW-1:0] n1;
    logic signed [NW-1:0] n2;
  } side_t;

endpackage
`default_nettype wire

>>> rtl/core/rotation_matrix_to_quaternion.sv
// rotation matrix (Q1.14) to unit quaternion, Shepperd's method
// stages from request to result: 1 setup, 16 square root, 24 divide, 1 output
// throughput one matrix per cycle; the whole pipe holds while a result waits on tready
// reset clears the valid bits only; no other state
// depends on rmq_pkg, rmq_sqrt, rmq_div
`default_nettype none
module rotation_matrix_to_quaternion
  import rmq_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [143:0] s_axis_tdata_i,   // m0..m8, 16 bits each, m0 lowest
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic      [63:0]  m_axis_tdata_o    // qx, qy, qz, qw, 16 bits each, qx lowest
);

  localparam int unsigned NST = 1 + SQRT_STAGES + DIV_STAGES + 1;

  // global stall: everything moves unless a result sits untaken
  logic en;
  logic vld_q [NST];

  assign en              = ~vld_q[NST-1] | m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NST; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= s_axis_tvalid_i;
      for (int k = 1; k < NST; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // setup stage: branch choice, radicand, numerators
  logic signed [18:0] e [9];
  for (genvar i = 0; i < 9; i++) begin : g_elem
    assign e[i] = 19'(signed'(s_axis_tdata_i[16*i +: 16]));
  end

  logic signed [18:0] trace, arg;
  logic        [31:0] rad_d;
  side_t              side_d;
  localparam logic signed [18:0] ONE19 = 19'(Q_ONE);

  assign trace = e[0] + e[4] + e[8];

  always_comb begin
    priority if (trace > 19'sd0) begin
      side_d.sel = SEL_W;
      arg        = ONE19 + trace;
      side_d.n0  = NW'(e[5] - e[7]);
      side_d.n1  = NW'(e[6] - e[2]);
      side_d.n2  = NW'(e[1] - e[3]);
    end else if (e[0] > e[4] && e[0] > e[8]) begin
      side_d.sel = SEL_X;
      arg        = ONE19 + e[0] - e[4] - e[8];
      side_d.n0  = NW'(e[5] - e[7]);
      side_d.n1  = NW'(e[1] + e[3]);
      side_d.n2  = NW'(e[6] + e[2]);
    end else if (e[4] > e[8]) begin
      side_d.sel = SEL_Y;
      arg        = ONE19 + e[4] - e[0] - e[8];
      side_d.n0  = NW'(e[6] - e[2]);
      side_d.n1  = NW'(e[1] + e[3]);
      side_d.n2  = NW'(e[5] + e[7]);
    end else begin
      side_d.sel = SEL_Z;
      arg        = ONE19 + e[8] - e[0] - e[4];
      side_d.n0  = NW'(e[1] - e[3]);
      side_d.n1  = NW'(e[6] + e[2]);
      side_d.n2  = NW'(e[5] + e[7]);
    end
    // clamp the argument at one lsb so the divisor never vanishes
    if (arg < 19'sd1) begin
      rad_d = {1'b0, 17'd1, 14'b0};
    end else begin
      rad_d = {1'b0, arg[16:0], 14'b0};
    end
  end

  logic [31:0] rad_q;
  side_t       side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q  <= rad_d;
      side_q <= side_d;
    end
  end

  // square root r = floor(sqrt(a * 2^14))
  logic [15:0] root;
  side_t       side_r;

  rmq_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad_q),
    .side_i (side_q),
    .root_o (root),
    .side_o (side_r)
  );

  // three divider lanes for the off-diagonal terms
  logic [QUO_W-1:0] quo [3];
  logic             neg [3];
  logic signed [NW-1:0] nums [3];

  assign nums[0] = side_r.n0;
  assign nums[1] = side_r.n1;
  assign nums[2] = side_r.n2;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    rmq_div u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (nums[l]),
      .root_i (root),
      .quo_o  (quo[l]),
      .neg_o  (neg[l])
    );
  end

  // r/2 rounded half up, delayed alongside the dividers with the selector
  logic [16:0] root_inc;
  logic [15:0] half_q [DIV_STAGES];
  sel_e        sel_q  [DIV_STAGES];

  assign root_inc = {1'b0, root} + 17'd1;

  always_ff @(posedge clk_i) begin
    if (en) begin
      half_q[0] <= root_inc[16:1];
      sel_q[0]  <= side_r.sel;
      for (int k = 1; k < DIV_STAGES; k++) begin
        half_q[k] <= half_q[k-1];
        sel_q[k]  <= sel_q[k-1];
      end
    end
  end

  // saturate and route to the output slots
  logic [15:0] half_s;
  logic [15:0] part [3];

  assign half_s = (half_q[DIV_STAGES-1] > Q_ONE) ? Q_ONE : half_q[DIV_STAGES-1];

  for (genvar l = 0; l < 3; l++) begin : g_sat
    logic [15:0] mag_s;
    assign mag_s   = (quo[l] > QUO_W'(Q_ONE)) ? Q_ONE : quo[l][15:0];
    assign part[l] = neg[l] ? 16'(-mag_s) : mag_s;
  end

  logic [63:0] tdata_d, tdata_q;

  always_comb begin
    unique case (sel_q[DIV_STAGES-1])
      SEL_W:   tdata_d = {half_s,  part[2], part[1], part[0]};
      SEL_X:   tdata_d = {part[0], part[2], part[1], half_s};
      SEL_Y:   tdata_d = {part[0], part[2], half_s,  part[1]};
      SEL_Z:   tdata_d = {part[0], half_s,  part[2], part[1]};
      default: tdata_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tdata_q <= tdata_d;
    end
  end

  assign m_axis_tdata_o = tdata_q;

endmodule
`default_nettype wire

>>> rtl/core/rmq_sqrt.sv
// pipelined integer square root, two radicand bits and one root bit per stage
// depends on rmq_pkg
`default_nettype none
module rmq_sqrt
  import rmq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] rad_i,
  input  wire side_t       side_i,
  output logic      [15:0] root_o,
  output side_t            side_o
);

  logic [19:0] rem_q  [SQRT_STAGES];
  logic [15:0] root_q [SQRT_STAGES];
  logic [31:0] rad_q  [SQRT_STAGES];
  side_t       side_q [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    logic [19:0] rem_in, rem_s, trial;
    logic [15:0] root_in;
    logic [31:0] rad_in;
    side_t       side_in;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign rem_s = {rem_in[17:0], rad_in[31:30]};
    assign trial = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_s >= trial) begin
          rem_q[k]  <= rem_s - trial;
          root_q[k] <= {root_in[14:0], 1'b1};
        end else begin
          rem_q[k]  <= rem_s;
          root_q[k] <= {root_in[14:0], 1'b0};
        end
        rad_q[k]  <= {rad_in[29:0], 2'b00};
        side_q[k] <= side_in;
      end
    end
  end

  assign root_o = root_q[SQRT_STAGES-1];
  assign side_o = side_q[SQRT_STAGES-1];

endmodule
`default_nettype wire

>>> rtl/core/rmq_div.sv
// one divider lane: round(|num| * 2^14 / (2r)), one quotient bit per stage
// depends on rmq_pkg
`default_nettype none
module rmq_div
  import rmq_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic signed [NW-1:0] num_i,
  input  wire logic        [15:0]   root_i,
  output logic             [QUO_W-1:0] quo_o,
  output logic                      neg_o
);

  logic [NW-1:0] mag;
  logic [31:0]   dvd;

  assign mag = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
  // rounding term r is half the divisor
  assign dvd = {1'b0, mag[16:0], 14'b0} + {16'b0, root_i};

  logic [17:0]      rem_q [DIV_STAGES];
  logic [16:0]      den_q [DIV_STAGES];
  logic [23:0]      low_q [DIV_STAGES];
  logic [QUO_W-1:0] quo_q [DIV_STAGES];
  logic             neg_q [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [17:0]      rem_in, rem_s;
    logic [16:0]      den_in;
    logic [23:0]      low_in;
    logic [QUO_W-1:0] quo_in;
    logic             neg_in;

    if (k == 0) begin : g_first
      // top byte is always below the divisor (r >= 128)
      assign rem_in = {10'b0, dvd[31:24]};
      assign den_in = {root_i, 1'b0};
      assign low_in = dvd[23:0];
      assign quo_in = '0;
      assign neg_in = num_i[NW-1];
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign low_in = low_q[k-1];
      assign quo_in = quo_q[k-1];
      assign neg_in = neg_q[k-1];
    end

    assign rem_s = {rem_in[16:0], low_in[23]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_s >= {1'b0, den_in}) begin
          rem_q[k] <= rem_s - {1'b0, den_in};
          quo_q[k] <= {quo_in[QUO_W-2:0], 1'b1};
        end else begin
          rem_q[k] <= rem_s;
          quo_q[k] <= {quo_in[QUO_W-2:0], 1'b0};
        end
        den_q[k] <= den_in;
        low_q[k] <= {low_in[22:0], 1'b0};
        neg_q[k] <= neg_in;
      end
    end
  end

  assign quo_o = quo_q[DIV_STAGES-1];
  assign neg_o = neg_q[DIV_STAGES-1];

endmodule
`default_nettype wire
